### sv/spatial_grid_bucket_insert_assert.svh
`ifndef SPATIAL_GRID_BUCKET_INSERT_ASSERT_SVH
`define SPATIAL_GRID_BUCKET_INSERT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGBI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SGBI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sgbi_pkg.sv
package sgbi_pkg;

  localparam int GRID_COLS_DEF    = 128;
  localparam int GRID_ROWS_DEF    = 128;
  localparam int POOL_ENTRIES_DEF = 1024;

  localparam int HANDLE_W    = 10;
  localparam int COORD_W     = 16;
  localparam int COORDS_W    = 3 * COORD_W;
  localparam int CELL_OUT_W  = 14;
  localparam int FIELD_LSB   = 8;
  localparam int FIELD_W     = 7;
  localparam int FIELD_DEPTH = 1 << FIELD_W;
  localparam int RECIP_SHIFT = 20;
  localparam int PROD_W      = HANDLE_W + RECIP_SHIFT;
  localparam int HANDLE_SPAN = 1 << HANDLE_W;

  typedef struct packed {
    logic rd;
    logic upd;
    logic link;
    logic fix;
  } mem_ctl_t;

endpackage

### sv/spatial_grid_bucket_insert.sv
// Channel  Handshake             Payload
// input    in_valid / in_stall   object_handle, coord_a, coord_b, coord_d
// output   out_valid / out_stall cell_index, newly_linked, old_head
//
// An item steps through transfer, memory read of the linked flag and cell head, then
// write back. The next item may transfer in the cycle that writes the old head's prev link.
// After reset a clearing pass over max(GRID_COLS*GRID_ROWS, POOL_ENTRIES) entries zeroes the
// cell heads and linked flags; in_stall is high throughout.
// A stalled result holds the write back until the output register frees up.
module spatial_grid_bucket_insert #(
  parameter int GRID_COLS    = sgbi_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS    = sgbi_pkg::GRID_ROWS_DEF,
  parameter int POOL_ENTRIES = sgbi_pkg::POOL_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sgbi_pkg::HANDLE_W-1:0]      object_handle,
  input  logic [sgbi_pkg::COORD_W-1:0]       coord_a,
  input  logic [sgbi_pkg::COORD_W-1:0]       coord_b,
  input  logic [sgbi_pkg::COORD_W-1:0]       coord_d,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sgbi_pkg::CELL_OUT_W-1:0]    cell_index,
  output logic                               newly_linked,
  output logic [sgbi_pkg::HANDLE_W-1:0]      old_head
);
  import sgbi_pkg::*;

  `include "spatial_grid_bucket_insert_assert.svh"

  localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
  localparam int HW         = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int CW         = $clog2(CELL_COUNT);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_WR   = 4'b0100,
    ST_FIX  = 4'b1000
  } state_t;

  state_t              state;
  state_t              state_next;
  mem_ctl_t            ctl;
  logic                in_xfer;
  logic                out_load;
  logic                live;
  logic                ins;
  logic                clearing;
  logic [HW-1:0]       handle;
  logic [CW-1:0]       cell_idx;
  logic [COORDS_W-1:0] coords;
  logic [HANDLE_W-1:0] head_q;
  logic                flag_q;

  sgbi_addr #(
    .GRID_COLS    (GRID_COLS),
    .GRID_ROWS    (GRID_ROWS),
    .POOL_ENTRIES (POOL_ENTRIES),
    .HW           (HW),
    .CW           (CW)
  ) u_addr (
    .clk           (clk),
    .load          (in_xfer),
    .object_handle (object_handle),
    .coord_a       (coord_a),
    .coord_b       (coord_b),
    .coord_d       (coord_d),
    .handle        (handle),
    .cell_idx      (cell_idx),
    .coords        (coords)
  );

  sgbi_store #(
    .CELL_COUNT   (CELL_COUNT),
    .POOL_ENTRIES (POOL_ENTRIES),
    .HW           (HW),
    .CW           (CW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .handle   (handle),
    .cell_idx (cell_idx),
    .coords   (coords),
    .head_q   (head_q),
    .flag_q   (flag_q),
    .clearing (clearing)
  );

  assign in_stall = clearing || !(state == ST_IDLE || state == ST_FIX);
  assign in_xfer  = in_valid && !in_stall;
  assign live     = handle != '0;
  assign ins      = live && !flag_q;

  always_comb begin
    state_next = state;
    ctl        = '0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        ctl.rd     = 1'b1;
        state_next = ST_WR;
      end
      ST_WR: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          ctl.upd    = live;
          ctl.link   = ins;
          state_next = (ins && head_q != '0) ? ST_FIX : ST_IDLE;
        end
      end
      ST_FIX: begin
        ctl.fix    = 1'b1;
        state_next = in_xfer ? ST_RD : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cell_index   <= CELL_OUT_W'(cell_idx);
      newly_linked <= ins;
      old_head     <= ins ? head_q : '0;
    end
  end

  `SGBI_ASSERT_NEXT(a_read_follows_transfer, in_xfer, state == ST_RD, "read did not follow transfer")
  `SGBI_ASSERT_SAME(a_fix_after_link, ctl.fix, $past(ctl.link), "prev fix without a link write")
  `SGBI_ASSERT_SAME(a_idle_while_clearing, clearing, state == ST_IDLE, "item in flight during clear")
  `SGBI_ASSERT_SAME(a_no_head_unlinked, out_valid && !newly_linked, old_head == '0, "old head on no insert")

endmodule

### sv/sgbi_addr.sv
module sgbi_addr #(
  parameter int GRID_COLS    = sgbi_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS    = sgbi_pkg::GRID_ROWS_DEF,
  parameter int POOL_ENTRIES = sgbi_pkg::POOL_ENTRIES_DEF,
  parameter int HW           = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1,
  parameter int CW           = $clog2(GRID_COLS * GRID_ROWS)
) (
  input  logic                                clk,
  input  logic                                load,
  input  logic [sgbi_pkg::HANDLE_W-1:0]       object_handle,
  input  logic [sgbi_pkg::COORD_W-1:0]        coord_a,
  input  logic [sgbi_pkg::COORD_W-1:0]        coord_b,
  input  logic [sgbi_pkg::COORD_W-1:0]        coord_d,
  output logic [HW-1:0]                       handle,
  output logic [CW-1:0]                       cell_idx,
  output logic [sgbi_pkg::COORDS_W-1:0]       coords
);
  import sgbi_pkg::*;

  logic [FIELD_W-1:0]  col_lut [FIELD_DEPTH];
  logic [FIELD_W-1:0]  row_lut [FIELD_DEPTH];
  logic [FIELD_W-1:0]  col;
  logic [FIELD_W-1:0]  row;
  logic [CW-1:0]       cell_calc;
  logic [HANDLE_W-1:0] h_raw;

  for (genvar i = 0; i < FIELD_DEPTH; i++) begin : g_lut
    assign col_lut[i] = FIELD_W'(i % GRID_COLS);
    assign row_lut[i] = FIELD_W'(i % GRID_ROWS);
  end

  assign col       = col_lut[coord_a[FIELD_LSB +: FIELD_W]];
  assign row       = row_lut[coord_b[FIELD_LSB +: FIELD_W]];
  assign cell_calc = CW'(row) * CW'(GRID_COLS) + CW'(col);

  always_ff @(posedge clk) begin
    if (load) begin
      h_raw    <= object_handle;
      cell_idx <= cell_calc;
      coords   <= {coord_d, coord_b, coord_a};
    end
  end

  if (POOL_ENTRIES >= HANDLE_SPAN) begin : g_wide_pool
    assign handle = HW'(h_raw);
  end else begin : g_narrow_pool
    // Remainder by reciprocal: the quotient estimate is low by at most one.
    localparam int RECIP = (1 << RECIP_SHIFT) / POOL_ENTRIES;
    localparam int RW    = HANDLE_W + 1;

    logic [PROD_W-1:0]   prod;
    logic [HANDLE_W-1:0] q_est;
    logic [RW-1:0]       qp;
    logic [RW-1:0]       rem_est;
    logic [RW-1:0]       rem;

    assign prod = PROD_W'(object_handle) * PROD_W'(RECIP);

    always_ff @(posedge clk) begin
      if (load) begin
        q_est <= prod[PROD_W-1:RECIP_SHIFT];
      end
    end

    assign qp      = RW'(q_est) * RW'(POOL_ENTRIES);
    assign rem_est = RW'(h_raw) - qp;
    assign rem     = (rem_est >= RW'(POOL_ENTRIES)) ? rem_est - RW'(POOL_ENTRIES) : rem_est;
    assign handle  = HW'(rem);
  end

endmodule

### sv/sgbi_store.sv
module sgbi_store #(
  parameter int CELL_COUNT   = sgbi_pkg::GRID_COLS_DEF * sgbi_pkg::GRID_ROWS_DEF,
  parameter int POOL_ENTRIES = sgbi_pkg::POOL_ENTRIES_DEF,
  parameter int HW           = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1,
  parameter int CW           = $clog2(CELL_COUNT)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sgbi_pkg::mem_ctl_t                ctl,
  input  logic [HW-1:0]                     handle,
  input  logic [CW-1:0]                     cell_idx,
  input  logic [sgbi_pkg::COORDS_W-1:0]     coords,
  output logic [sgbi_pkg::HANDLE_W-1:0]     head_q,
  output logic                              flag_q,
  output logic                              clearing
);
  import sgbi_pkg::*;

  localparam int CLEAR_DEPTH = (CELL_COUNT > POOL_ENTRIES) ? CELL_COUNT : POOL_ENTRIES;
  localparam int KW          = $clog2(CLEAR_DEPTH);

  logic [HANDLE_W-1:0] heads       [CELL_COUNT];
  logic                flags       [POOL_ENTRIES];
  logic [HANDLE_W-1:0] next_links  [POOL_ENTRIES];
  logic [HANDLE_W-1:0] prev_links  [POOL_ENTRIES];
  logic [COORDS_W-1:0] coord_store [POOL_ENTRIES];

  logic [KW-1:0]       cnt;
  logic                cnt_in_cells;
  logic                cnt_in_pool;
  logic [HW-1:0]       prev_addr;
  logic [HANDLE_W-1:0] prev_val;
  logic [HANDLE_W-1:0] link_val;

  assign cnt_in_cells = 32'(cnt) < CELL_COUNT;
  assign cnt_in_pool  = 32'(cnt) < POOL_ENTRIES;
  assign link_val     = HANDLE_W'(handle);
  assign prev_addr    = ctl.fix ? HW'(head_q) : handle;
  assign prev_val     = ctl.fix ? link_val : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      cnt      <= '0;
    end else if (clearing) begin
      cnt <= cnt + 1'b1;
      if (cnt == KW'(CLEAR_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      if (cnt_in_cells) begin
        heads[cnt[CW-1:0]] <= '0;
      end
    end else if (ctl.link) begin
      heads[cell_idx] <= link_val;
    end
    if (ctl.rd) begin
      head_q <= heads[cell_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      if (cnt_in_pool) begin
        flags[cnt[HW-1:0]] <= 1'b0;
      end
    end else if (ctl.link) begin
      flags[handle] <= 1'b1;
    end
    if (ctl.rd) begin
      flag_q <= flags[handle];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.link) begin
      next_links[handle] <= head_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.link || ctl.fix) begin
      prev_links[prev_addr] <= prev_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      coord_store[handle] <= coords;
    end
  end

endmodule

### sim/spatial_grid_bucket_insert_test.sv
module spatial_grid_bucket_insert_test;
  import sgbi_pkg::*;

  localparam int CELL_COUNT  = GRID_COLS_DEF * GRID_ROWS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1033;
  localparam int HOT_CELLS   = 6;

  typedef struct {
    logic [CELL_OUT_W-1:0] cell_idx;
    logic                  newly;
    logic [HANDLE_W-1:0]   old;
  } placement_t;

  typedef struct {
    logic [HANDLE_W-1:0] handle;
    logic [COORD_W-1:0]  a;
    logic [COORD_W-1:0]  b;
    logic [COORD_W-1:0]  d;
    bit                  known;
    placement_t          result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [HANDLE_W-1:0] object_handle = '0;
  logic [COORD_W-1:0] coord_a = '0;
  logic [COORD_W-1:0] coord_b = '0;
  logic [COORD_W-1:0] coord_d = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CELL_OUT_W-1:0] cell_index;
  logic newly_linked;
  logic [HANDLE_W-1:0] old_head;

  logic [HANDLE_W-1:0] head_of_cell [CELL_COUNT];
  bit is_linked [POOL_ENTRIES_DEF];
  placement_t pending_placements [$];
  int error_count = 0;
  int cycles = 0;
  bit want_hold = 0;
  logic [FIELD_W-1:0] hot_col [HOT_CELLS];
  logic [FIELD_W-1:0] hot_row [HOT_CELLS];

  stim_row_t directed [] = '{
    '{10'd1,    16'h0000, 16'h0000, 16'h0000, 1, '{14'd0,     1'b1, 10'd0}},
    '{10'd1023, 16'h00ff, 16'h00ff, 16'hffff, 1, '{14'd0,     1'b1, 10'd1}},
    '{10'd512,  16'h80ff, 16'h8000, 16'h8000, 1, '{14'd0,     1'b1, 10'd1023}},
    '{10'd0,    16'hffff, 16'hffff, 16'hffff, 1, '{14'd16383, 1'b0, 10'd0}},
    '{10'd1,    16'h7f00, 16'h0000, 16'h1234, 1, '{14'd127,   1'b0, 10'd0}},
    '{10'd2,    16'h7f00, 16'h0000, 16'h0000, 1, '{14'd127,   1'b1, 10'd0}},
    '{10'd3,    16'h0000, 16'h7f00, 16'h0000, 1, '{14'd16256, 1'b1, 10'd0}},
    '{10'd1022, 16'hffff, 16'hffff, 16'h5555, 1, '{14'd16383, 1'b1, 10'd0}},
    '{10'd682,  16'h7fff, 16'h7fff, 16'haaaa, 1, '{14'd16383, 1'b1, 10'd1022}},
    '{10'd341,  16'h5500, 16'h2a00, 16'h0f0f, 1, '{14'd5461,  1'b1, 10'd0}},
    '{10'd0,    16'h1234, 16'h5678, 16'h9abc, 0, '{14'd0, 1'b0, 10'd0}},
    '{10'd1023, 16'h7f00, 16'h0000, 16'h0000, 1, '{14'd127,   1'b0, 10'd0}},
    '{10'd4,    16'h0100, 16'h0100, 16'h0001, 0, '{14'd0, 1'b0, 10'd0}},
    '{10'd5,    16'h81a5, 16'h815a, 16'h0002, 0, '{14'd0, 1'b0, 10'd0}},
    '{10'd6,    16'h0101, 16'h01fe, 16'h0003, 0, '{14'd0, 1'b0, 10'd0}},
    '{10'd1023, 16'h0100, 16'h0100, 16'h0004, 0, '{14'd0, 1'b0, 10'd0}},
    '{10'd7,    16'h7f00, 16'h0000, 16'hf00f, 0, '{14'd0, 1'b0, 10'd0}}
  };

  spatial_grid_bucket_insert DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .object_handle(object_handle),
    .coord_a(coord_a),
    .coord_b(coord_b),
    .coord_d(coord_d),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cell_index(cell_index),
    .newly_linked(newly_linked),
    .old_head(old_head)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic placement_t place_object(logic [HANDLE_W-1:0] handle,
                                              logic [COORD_W-1:0] a,
                                              logic [COORD_W-1:0] b);
    placement_t res;
    int col;
    int row;
    col = a[FIELD_LSB +: FIELD_W] % GRID_COLS_DEF;
    row = b[FIELD_LSB +: FIELD_W] % GRID_ROWS_DEF;
    res.cell_idx = CELL_OUT_W'(row * GRID_COLS_DEF + col);
    res.newly = 1'b0;
    res.old = '0;
    if (handle != 0 && !is_linked[handle]) begin
      res.old = head_of_cell[res.cell_idx];
      res.newly = 1'b1;
      head_of_cell[res.cell_idx] = handle;
      is_linked[handle] = 1;
    end
    return res;
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_handle(bit want_linked);
    logic [HANDLE_W-1:0] h;
    repeat (32) begin
      h = HANDLE_W'($urandom_range(1, 1023));
      if (is_linked[h] == want_linked) return h;
    end
    for (int i = 1; i < POOL_ENTRIES_DEF; i++) begin
      if (is_linked[i] == want_linked) return HANDLE_W'(i);
    end
    return HANDLE_W'($urandom_range(1, 1023));
  endfunction

  task automatic offer(logic [HANDLE_W-1:0] h, logic [COORD_W-1:0] a,
                       logic [COORD_W-1:0] b, logic [COORD_W-1:0] d);
    in_valid <= 1'b1;
    object_handle <= h;
    coord_a <= a;
    coord_b <= b;
    coord_d <= d;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic pause_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_placements.size() != 0) @(posedge clk);
  endtask

  // Receiver: checks each transfer and stalls in modes of random length, or for a hold on request.
  initial begin
    placement_t exp;
    int hold_left;
    int mode;
    int mode_left;
    logic nxt;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_placements.size() == 0) begin
          $error("unexpected result: cell_index %0d newly_linked %0d old_head %0d",
                 cell_index, newly_linked, old_head);
          error_count++;
        end else begin
          exp = pending_placements.pop_front();
          if (cell_index !== exp.cell_idx) begin
            $error("cell_index: expected %0d, actual %0d", exp.cell_idx, cell_index);
            error_count++;
          end
          if (newly_linked !== exp.newly) begin
            $error("newly_linked: expected %0d, actual %0d", exp.newly, newly_linked);
            error_count++;
          end
          if (old_head !== exp.old) begin
            $error("old_head: expected %0d, actual %0d", exp.old, old_head);
            error_count++;
          end
        end
      end
      if (want_hold) begin
        hold_left = 400;
        want_hold = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: nxt = 1'b0;
          1: nxt = ($urandom_range(0, 1) == 1);
          2: nxt = ($urandom_range(0, 3) != 0);
          default: nxt = mode_left[2];
        endcase
      end
      out_stall <= nxt;
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("spatial_grid_bucket_insert_test: FAIL");
    $finish;
  end

  initial begin
    placement_t res;
    logic [HANDLE_W-1:0] h;
    logic [COORD_W-1:0] a;
    logic [COORD_W-1:0] b;
    logic [COORD_W-1:0] d;
    int kind;
    int k;
    int burst_left;
    for (int i = 0; i < CELL_COUNT; i++) head_of_cell[i] = '0;
    for (int i = 0; i < POOL_ENTRIES_DEF; i++) is_linked[i] = 0;
    for (int i = 0; i < HOT_CELLS; i++) begin
      hot_col[i] = FIELD_W'($urandom_range(0, 127));
      hot_row[i] = FIELD_W'($urandom_range(0, 127));
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      offer(directed[i].handle, directed[i].a, directed[i].b, directed[i].d);
      res = place_object(directed[i].handle, directed[i].a, directed[i].b);
      pending_placements.push_back(directed[i].known ? directed[i].result : res);
    end

    // Most random items are fresh objects piled into a few hot cells, so that
    // the cell lists grow long and old_head is usually a live object.
    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) want_hold = 1;
      if (i == 650) wait_drained();
      kind = $urandom_range(0, 99);
      a = COORD_W'($urandom_range(0, 65535));
      b = COORD_W'($urandom_range(0, 65535));
      d = COORD_W'($urandom_range(0, 65535));
      if (kind < 60) begin
        h = pick_handle(0);
        k = $urandom_range(0, HOT_CELLS - 1);
        a[FIELD_LSB +: FIELD_W] = hot_col[k];
        b[FIELD_LSB +: FIELD_W] = hot_row[k];
      end else if (kind < 75) begin
        h = pick_handle(0);
      end else if (kind < 90) begin
        h = pick_handle(1);
      end else if (kind < 95) begin
        h = '0;
      end else begin
        h = HANDLE_W'($urandom_range(0, 1023));
      end
      offer(h, a, b, d);
      pending_placements.push_back(place_object(h, a, b));
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        if (!(i >= 300 && i < 360) && $urandom_range(0, 3) != 0) begin
          pause_sender($urandom_range(1, 8));
        end
      end else begin
        burst_left--;
      end
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("spatial_grid_bucket_insert_test: PASS");
    end else begin
      $display("spatial_grid_bucket_insert_test: FAIL");
    end
    $finish;
  end

endmodule

### spatial_grid_bucket_insert.f
+incdir+sv
sv/sgbi_pkg.sv
sv/sgbi_addr.sv
sv/sgbi_store.sv
sv/spatial_grid_bucket_insert.sv
sim/spatial_grid_bucket_insert_test.sv
